### hw/rtl/ile_pkg.sv
`default_nettype none

package ile_pkg;

  // list geometry and field widths
  localparam int CAPACITY   = 256;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 9;
  localparam int CNT_W      = 9;
  localparam int OP_W       = 3;

  // read-back OR tree: first level groups the cells, second level joins groups
  localparam int TREE_GROUPS = 16;
  localparam int GROUP_SIZE  = CAPACITY / TREE_GROUPS;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  // broadcast action for the cell row
  typedef enum logic [2:0] {
    CK_HOLD,
    CK_INSERT,
    CK_REMOVE,
    CK_WRITE,
    CK_READ
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t         kind;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/ile_in_if.sv
`default_nettype none

interface ile_in_if import ile_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ile_out_if import ile_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         count;
  logic                     error;

  modport source (output valid, output read_value, output count, output error, input ready);
  modport sink   (input valid, input read_value, input count, input error, output ready);
endinterface

`default_nettype wire

### hw/rtl/ile_cell.sv
`default_nettype none

module ile_cell import ile_pkg::*; (
  input  wire logic              clk,
  input  wire cell_cmd_t         cmd,
  input  wire logic [POS_W-1:0]  idx,
  input  wire logic [DATA_W-1:0] left_val,
  input  wire logic [DATA_W-1:0] right_val,
  output logic      [DATA_W-1:0] entry_val,
  output logic      [DATA_W-1:0] tap_val
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic [DATA_W-1:0] tap_r;
  logic [DATA_W-1:0] tap_nxt;
  logic              hit;
  logic              above;

  assign hit   = (idx == cmd.pos);
  assign above = (idx > cmd.pos);

  // pick the next entry: shift from a neighbor, take the new value, or hold
  always_comb begin
    entry_nxt = entry_r;
    tap_nxt   = '0;
    case (cmd.kind)
      CK_INSERT: begin
        if (hit) begin
          entry_nxt = cmd.value;
        end else if (above) begin
          entry_nxt = left_val;
        end
      end
      CK_REMOVE: begin
        if (hit || above) begin
          entry_nxt = right_val;
        end
      end
      CK_WRITE: begin
        if (hit) begin
          entry_nxt = cmd.value;
        end
      end
      CK_READ: begin
        if (hit) begin
          tap_nxt = entry_r;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tap_r   <= tap_nxt;
  end

  assign entry_val = entry_r;
  assign tap_val   = tap_r;

endmodule

`default_nettype wire

### hw/rtl/ile_or_tree.sv
`default_nettype none

module ile_or_tree import ile_pkg::*; (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [DATA_W-1:0] taps [CAPACITY],
  output logic      [DATA_W-1:0] result
);

  logic [DATA_W-1:0] grp_r   [TREE_GROUPS];
  logic [DATA_W-1:0] grp_nxt [TREE_GROUPS];

  // first level: OR each group of cell taps (only the hit cell is nonzero)
  always_comb begin
    for (int g = 0; g < TREE_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] | taps[g*GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_nxt;
    end
  end

  // second level: join the registered groups
  always_comb begin
    result = '0;
    for (int g = 0; g < TREE_GROUPS; g++) begin
      result = result | grp_r[g];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/indexed_list_engine.sv
// Each accepted input beat yields one result beat on out_ch.
// A single request is in flight: it passes the cell-row update, the registered
//   group OR stage and the output register, and in_ch.ready stays low until the
//   result loads into the output register, which waits while out_ch.ready is low.
// Insert and remove shift every cell at or above the position together.
// Reset (rst_n low, synchronous) empties the list and clears all handshake state;
//   entry contents are undefined until written.
`default_nettype none

module indexed_list_engine import ile_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ile_in_if.sink    in_ch,
  ile_out_if.source out_ch
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request capture
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  // stage valids and carried status
  logic             exec_v_r;
  logic             leaf_v_r;
  logic             grp_v_r;
  logic             leaf_err_r;
  logic             grp_err_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_err_r;

  logic              busy;
  logic              in_fire;
  logic              out_load;
  logic              exec_err;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] entries [CAPACITY];
  logic [DATA_W-1:0] taps    [CAPACITY];
  logic [DATA_W-1:0] tree_out;
  logic              full;
  logic              pos_lt;
  logic              pos_le;

  assign busy        = exec_v_r | leaf_v_r | grp_v_r;
  assign in_ch.ready = ~busy;
  assign in_fire     = in_ch.valid & ~busy;
  assign out_load    = grp_v_r & (~out_valid_r | out_ch.ready);

  assign full   = (count_r == CAP_CNT);
  assign pos_lt = (pos_r < count_r);
  assign pos_le = (pos_r <= count_r);

  // decode the request into a row command, an error and the new count
  always_comb begin
    cmd.kind  = CK_HOLD;
    cmd.pos   = pos_r;
    cmd.value = val_r;
    exec_err  = 1'b0;
    count_nxt = count_r;
    case (op_r)
      OP_APPEND: begin
        exec_err = full;
        cmd.pos  = count_r;
        if (!full) begin
          cmd.kind  = CK_WRITE;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        exec_err = full | ~pos_le;
        if (!full && pos_le) begin
          cmd.kind  = CK_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        exec_err = ~pos_lt;
        if (pos_lt) begin
          cmd.kind  = CK_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_OVERWRITE: begin
        exec_err = ~pos_lt;
        if (pos_lt) begin
          cmd.kind = CK_WRITE;
        end
      end
      OP_READ: begin
        exec_err = ~pos_lt;
        if (pos_lt) begin
          cmd.kind = CK_READ;
        end
      end
      default: begin
        exec_err = 1'b1;
      end
    endcase
    if (!exec_v_r) begin
      cmd.kind  = CK_HOLD;
      count_nxt = count_r;
    end
  end

  // capture the request payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.op;
      pos_r <= in_ch.position;
      val_r <= in_ch.value;
    end
  end

  // advance control through exec, leaf and group stages, then the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_v_r    <= 1'b0;
      leaf_v_r    <= 1'b0;
      grp_v_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      exec_v_r <= in_fire;
      leaf_v_r <= exec_v_r;
      count_r  <= count_nxt;
      if (leaf_v_r) begin
        grp_v_r <= 1'b1;
      end else if (out_load) begin
        grp_v_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // carry status alongside the read-back tree
  always_ff @(posedge clk) begin
    if (exec_v_r) begin
      leaf_err_r <= exec_err;
    end
    if (leaf_v_r) begin
      grp_err_r <= leaf_err_r;
    end
    if (out_load) begin
      out_data_r  <= tree_out;
      out_count_r <= count_r;
      out_err_r   <= grp_err_r;
    end
  end

  // row of cells, each linked to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = entries[i+1];
    end
    ile_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (POS_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .entry_val (entries[i]),
      .tap_val   (taps[i])
    );
  end

  ile_or_tree u_tree (
    .clk    (clk),
    .load   (leaf_v_r),
    .taps   (taps),
    .result (tree_out)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.error      = out_err_r;

endmodule

`default_nettype wire

### hw/rtl/ile_checker.sv
`default_nettype none

module ile_checker import ile_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_read_value,
  input wire logic [CNT_W-1:0]  out_count,
  input wire logic              out_error
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value))
    else $error("result beat dropped or changed while stalled");

  // refused requests return zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_read_value == '0)
    else $error("error result carries nonzero read value");

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // one request in flight: no accept right after an accept
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_value (out_ch.read_value),
  .out_count      (out_ch.count),
  .out_error      (out_ch.error)
);

`default_nettype wire

### tb/sv/indexed_list_engine_tb.sv
`timescale 1ns / 100ps

module indexed_list_engine_tb;
  import ile_pkg::*;

  // codes above the last defined request are refused by the block
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = 3'd7;
  localparam int RAND_ITEMS  = 1930;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int FULL_DWELL  = 24;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    int                       gap;
  } list_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     error;
  } list_resp_t;

  logic clk;
  logic rst_n;

  ile_in_if  in_ch ();
  ile_out_if out_ch ();

  indexed_list_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_req_t  pending_reqs[$];
  list_resp_t expected_resps[$];
  list_req_t  cur_req;

  // shadow list used to predict each response
  logic signed [DATA_W-1:0] shadow_mem [CAPACITY];
  int shadow_len;

  // length as the generator sees it, used only to aim indexes
  int gen_len;

  int hold_cycles;
  int stall_left;
  int next_stall;
  int resps_seen;
  int fail_count;
  int cycle_count;

  // wait length per beat; every fourth stretch of 100 beats runs without gaps
  function automatic int draw_wait(int seq);
    if ((seq / 100) % 4 == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] draw_index(int limit);
    if (limit <= 0) return '0;
    return POS_W'($urandom_range(0, limit - 1));
  endfunction

  // apply one request to the shadow list and return the response it gives
  function automatic list_resp_t list_apply(list_req_t req);
    list_resp_t resp;
    int p;
    p = int'(req.pos);
    resp.read_value = '0;
    resp.error = 1'b0;
    case (req.op)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          resp.error = 1'b1;
        end else begin
          shadow_mem[shadow_len] = req.value;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (shadow_len >= CAPACITY || p > shadow_len) begin
          resp.error = 1'b1;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[p] = req.value;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (p >= shadow_len) begin
          resp.error = 1'b1;
        end else begin
          for (int i = p; i < shadow_len - 1; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end
      end
      OP_OVERWRITE: begin
        if (p >= shadow_len) resp.error = 1'b1;
        else shadow_mem[p] = req.value;
      end
      OP_READ: begin
        if (p >= shadow_len) resp.error = 1'b1;
        else resp.read_value = shadow_mem[p];
      end
      default: resp.error = 1'b1;
    endcase
    resp.count = CNT_W'(shadow_len);
    return resp;
  endfunction

  // queue a request and track the length it leaves behind
  task automatic queue_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] value);
    list_req_t req;
    int p;
    p = int'(pos);
    req.op = op;
    req.pos = pos;
    req.value = value;
    req.gap = draw_wait(pending_reqs.size());
    pending_reqs.push_back(req);
    case (op)
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_INSERT: if (gen_len < CAPACITY && p <= gen_len) gen_len++;
      OP_REMOVE: if (p < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at beat %0d: %s", resps_seen, msg);
    fail_count++;
  endtask

  task automatic check_resp();
    list_resp_t want;
    if (expected_resps.size() == 0) begin
      report_mismatch("response with nothing expected");
      return;
    end
    want = expected_resps.pop_front();
    if (out_ch.read_value !== want.read_value)
      report_mismatch($sformatf("read_value %0d, want %0d", out_ch.read_value,
                                want.read_value));
    if (out_ch.count !== want.count)
      report_mismatch($sformatf("count %0d, want %0d", out_ch.count, want.count));
    if (out_ch.error !== want.error)
      report_mismatch($sformatf("error %b, want %b", out_ch.error, want.error));
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver: present the next item once its gap has passed
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      hold_cycles <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_resps.push_back(list_apply(cur_req));
      if (pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (hold_cycles < pending_reqs[0].gap) begin
        in_ch.valid <= 1'b0;
        hold_cycles <= hold_cycles + 1;
      end else begin
        cur_req = pending_reqs.pop_front();
        in_ch.op <= cur_req.op;
        in_ch.position <= cur_req.pos;
        in_ch.value <= cur_req.value;
        in_ch.valid <= 1'b1;
        hold_cycles <= 0;
      end
    end
  end

  // response monitor: check each beat, then stall ready for a drawn time
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      check_resp();
      resps_seen++;
      next_stall = draw_wait(resps_seen);
      if (next_stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left <= next_stall;
      end
    end else if (!out_ch.ready) begin
      if (stall_left <= 1) out_ch.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // timeout watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit grow;
    int full_dwell;
    int roll;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_APPEND;
    in_ch.position = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    shadow_len = 0;
    gen_len = 0;
    resps_seen = 0;
    fail_count = 0;

    // directed: empty-list refusals
    queue_req(OP_READ, '0, '0);
    queue_req(OP_REMOVE, '0, '0);
    queue_req(OP_OVERWRITE, '0, 32'sh1234_5678);
    queue_req(OP_INSERT, 9'd1, 32'sh1111_1111);
    // directed: build a short list with extreme values
    queue_req(OP_INSERT, '0, 32'sh8000_0000);
    queue_req(OP_APPEND, '0, 32'sh7FFF_FFFF);
    queue_req(OP_APPEND, 9'd511, '1);
    queue_req(OP_APPEND, '0, '0);
    // insert at the count appends; insert inside shifts up
    queue_req(OP_INSERT, 9'd4, 32'sh5555_5555);
    queue_req(OP_INSERT, 9'd2, 32'shAAAA_AAAA);
    queue_req(OP_INSERT, 9'd7, 32'sh0F0F_0F0F);
    queue_req(OP_READ, 9'd2, '1);
    queue_req(OP_READ, 9'd5, '0);
    queue_req(OP_READ, 9'd6, '0);
    queue_req(OP_OVERWRITE, '0, 32'sh7FFF_FFFF);
    queue_req(OP_READ, '0, '0);
    queue_req(OP_REMOVE, '0, '0);
    queue_req(OP_REMOVE, 9'd4, '0);
    queue_req(OP_REMOVE, 9'd4, '0);
    queue_req(OP_READ, 9'd256, '0);
    queue_req(OP_OVERWRITE, 9'd255, 32'sh2222_2222);
    for (int c = OP_FIRST_UNUSED; c <= OP_LAST_CODE; c++)
      queue_req(OP_W'(c), 9'd1, 32'shDEAD_BEEF);

    // random: grow toward full, dwell there, then drain to empty, repeat
    grow = 1'b1;
    full_dwell = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_req(OP_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 511)),
                  draw_value());
      end else if (grow) begin
        if (roll < 46) queue_req(OP_APPEND, POS_W'($urandom), draw_value());
        else if (roll < 66) queue_req(OP_INSERT, POS_W'($urandom_range(0, gen_len)),
                                      draw_value());
        else if (roll < 76) queue_req(OP_REMOVE, draw_index(gen_len), draw_value());
        else if (roll < 88) queue_req(OP_OVERWRITE, draw_index(gen_len), draw_value());
        else queue_req(OP_READ, draw_index(gen_len), draw_value());
      end else begin
        if (roll < 20) queue_req(OP_APPEND, POS_W'($urandom), draw_value());
        else if (roll < 30) queue_req(OP_INSERT, POS_W'($urandom_range(0, gen_len)),
                                      draw_value());
        else if (roll < 70) queue_req(OP_REMOVE, draw_index(gen_len), draw_value());
        else if (roll < 85) queue_req(OP_OVERWRITE, draw_index(gen_len), draw_value());
        else queue_req(OP_READ, draw_index(gen_len), draw_value());
      end
      if (gen_len >= CAPACITY) begin
        full_dwell++;
        if (full_dwell >= FULL_DWELL) begin
          grow = 1'b0;
          full_dwell = 0;
        end
      end
      if (gen_len == 0) grow = 1'b1;
    end

    // hold reset low, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to go out, then for every response
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
